// ===== hw/rtl/lpm_pkg.sv =====
// Shared constants, types and codes for the lunar phase mask pixel block.
`timescale 1ns / 1ps
package lpm_pkg;

    localparam int COORD_BITS = 12;
    localparam int TRIG_BITS  = 16;
    localparam int DIM_BITS   = 13;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_W      = (TRIG_BITS > FRAC_BITS) ? TRIG_BITS : FRAC_BITS;
    localparam int ADDR_W     = 3;

    // doubled offsets from the centre
    localparam int DX_W   = ((COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS) + 1;
    localparam int SQ_W   = 2 * DX_W + 1;
    localparam int PROD_W = DX_W + TRIG_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RSH    = (TRIG_BITS > 16) ? TRIG_BITS - 16 : 0;
    localparam int LSH    = (TRIG_BITS < 16) ? 16 - TRIG_BITS : 0;
    localparam int XR_W   = SUM_W + LSH;
    localparam int WQ_W   = DIM_BITS + 15;
    localparam int RAD_W  = 2 * WQ_W;
    localparam int ROOT_W = WQ_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int MUL_W  = Q_W + ROOT_W + 1;
    localparam int CMP_W  = XR_W + 16;

    localparam logic [ADDR_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_COS    = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_SIN    = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_FRAC   = 3'd4;

    localparam logic [7:0] ALPHA_LIT     = 8'd0;
    localparam logic [7:0] ALPHA_SHADED  = 8'd196;
    localparam logic [7:0] ALPHA_OUTSIDE = 8'd255;

    typedef enum logic [1:0] {
        REGION_OUT   = 2'd0,
        REGION_LIT   = 2'd1,
        REGION_SHADE = 2'd2
    } t_region;

    // one word moving down the square root chain
    typedef struct packed {
        logic                    valid;
        logic                    in_disc;
        logic signed [XR_W-1:0]  xr;
        logic [RAD_W-1:0]        rad;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
    } t_cell;

endpackage

// ===== hw/rtl/lpm_front.sv =====
// Front pipeline: offsets, disc test, rotation and chord radicand.
`timescale 1ns / 1ps
module lpm_front import lpm_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [COORD_BITS-1:0]       i_pixel_x,
    input  logic [COORD_BITS-1:0]       i_pixel_y,
    input  logic [DIM_BITS-1:0]         i_width,
    input  logic [DIM_BITS-1:0]         i_height,
    input  logic signed [TRIG_BITS-1:0] i_cos,
    input  logic signed [TRIG_BITS-1:0] i_sin,
    output t_cell                       o_cell
);

    logic [4:0] r_vld;

    // stage 1: offsets
    logic signed [DX_W-1:0] r_dx, r_dy;
    // stage 2: products
    logic [2*DX_W-1:0]        r_dx2, r_dy2;
    logic [2*DIM_BITS-1:0]    r_w2;
    logic signed [PROD_W-1:0] r_xc, r_ys, r_xs, r_yc;
    // stage 3: sums
    logic                   r_in3;
    logic signed [XR_W-1:0] r_xr3, r_yr3;
    // stage 4: squares of the scaled radius and rotated y
    logic                   r_in4, r_zero;
    logic signed [XR_W-1:0] r_xr4;
    logic [RAD_W-1:0]       r_wq2, r_ya2;
    // stage 5: radicand
    logic                   r_in5;
    logic signed [XR_W-1:0] r_xr5;
    logic [RAD_W-1:0]       r_rad;

    logic signed [SUM_W-1:0] w_sx, w_sy;
    logic [XR_W-1:0]         w_ya;
    logic [WQ_W-1:0]         w_wq;

    assign w_sx = SUM_W'(r_xc) - SUM_W'(r_ys);
    assign w_sy = SUM_W'(r_xs) + SUM_W'(r_yc);
    assign w_ya = r_yr3[XR_W-1] ? XR_W'(-r_yr3) : XR_W'(r_yr3);
    assign w_wq = {i_width, 15'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= $signed(DX_W'({i_pixel_x, 1'b0})) - $signed(DX_W'(i_width));
        r_dy  <= $signed(DX_W'({i_pixel_y, 1'b0})) - $signed(DX_W'(i_height));

        r_dx2 <= (2*DX_W)'(r_dx * r_dx);
        r_dy2 <= (2*DX_W)'(r_dy * r_dy);
        r_w2  <= i_width * i_width;
        r_xc  <= PROD_W'(r_dx * i_cos);
        r_ys  <= PROD_W'(r_dy * i_sin);
        r_xs  <= PROD_W'(r_dx * i_sin);
        r_yc  <= PROD_W'(r_dy * i_cos);

        r_in3 <= (SQ_W'(r_dx2) + SQ_W'(r_dy2)) < SQ_W'(r_w2);
        r_xr3 <= (XR_W'(w_sx) >>> RSH) <<< LSH;
        r_yr3 <= (XR_W'(w_sy) >>> RSH) <<< LSH;

        r_in4  <= r_in3;
        r_xr4  <= r_xr3;
        r_zero <= w_ya >= XR_W'(w_wq);
        r_wq2  <= w_wq * w_wq;
        r_ya2  <= w_ya[WQ_W-1:0] * w_ya[WQ_W-1:0];

        r_in5 <= r_in4;
        r_xr5 <= r_xr4;
        r_rad <= r_zero ? '0 : r_wq2 - r_ya2;
    end

    always_comb begin
        o_cell         = '0;
        o_cell.valid   = r_vld[4];
        o_cell.in_disc = r_in5;
        o_cell.xr      = r_xr5;
        o_cell.rad     = r_rad;
    end

endmodule

// ===== hw/rtl/lpm_sqrt_cell.sv =====
// One digit cell of the square root chain: resolves one root bit per word.
`timescale 1ns / 1ps
module lpm_sqrt_cell import lpm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_cell,
    output t_cell o_cell
);

    t_cell             r_cell;
    t_cell             n_cell;
    logic [REM_W-1:0]  w_rem;
    logic [REM_W-1:0]  w_trial;

    assign w_rem   = {i_cell.rem[REM_W-3:0], i_cell.rad[RAD_W-1 -: 2]};
    assign w_trial = REM_W'({i_cell.root, 2'b01});

    always_comb begin
        n_cell     = i_cell;
        n_cell.rad = {i_cell.rad[RAD_W-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_cell.rem  = w_rem - w_trial;
            n_cell.root = {i_cell.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_cell.rem  = w_rem;
            n_cell.root = {i_cell.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.in_disc <= n_cell.in_disc;
        r_cell.xr      <= n_cell.xr;
        r_cell.rad     <= n_cell.rad;
        r_cell.rem     <= n_cell.rem;
        r_cell.root    <= n_cell.root;
    end

    assign o_cell = r_cell;

endmodule

// ===== hw/rtl/lunar_phase_mask_pixel.sv =====
// Top level of the lunar phase mask pixel block: config, root chain, decision.
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------
// pixel    | in        | i_start, o_busy      | i_pixel_x, i_pixel_y
// result   | out       | o_valid strobe       | o_alpha, o_region
// config   | in        | i_cfg_we             | i_cfg_addr, i_cfg_wdata
//
// One pixel word per clock; o_busy is always low. Each pixel passes
// through 5 front stages, one sqrt cell per root bit (28), and 2
// decision stages. The chord root sets the depth.
// Reset is synchronous, active low, clears every valid flag and loads the
// config registers with their defaults. The receiver takes each result in
// its strobe cycle.
`timescale 1ns / 1ps
module lunar_phase_mask_pixel import lpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    output logic                  o_valid,
    output logic [7:0]            o_alpha,
    output logic [1:0]            o_region,
    input  logic                  i_cfg_we,
    input  logic [ADDR_W-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    // configuration registers
    logic [DIM_BITS-1:0]         r_width, r_height;
    logic signed [TRIG_BITS-1:0] r_cos, r_sin;
    logic [FRAC_BITS-1:0]        r_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_BITS'(256);
            r_height <= DIM_BITS'(256);
            r_cos    <= TRIG_BITS'(32767);
            r_sin    <= '0;
            r_frac   <= FRAC_BITS'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH:  r_width  <= i_cfg_wdata[DIM_BITS-1:0];
                CFG_HEIGHT: r_height <= i_cfg_wdata[DIM_BITS-1:0];
                CFG_COS:    r_cos    <= i_cfg_wdata[TRIG_BITS-1:0];
                CFG_SIN:    r_sin    <= i_cfg_wdata[TRIG_BITS-1:0];
                CFG_FRAC:   r_frac   <= i_cfg_wdata[FRAC_BITS-1:0];
                default: ;   // drop writes to unused indexes
            endcase
        end
    end

    // never stall the raster
    assign o_busy = 1'b0;

    t_cell w_chain [ROOT_W+1];

    lpm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_cos     (r_cos),
        .i_sin     (r_sin),
        .o_cell    (w_chain[0])
    );

    // one cell per root bit, MSB first; each word advances a cell per clock
    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        lpm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // decision: lit when xr * 2^15 <= (frac - 1/2) * 2^16 * chord
    t_cell                   w_last;
    logic signed [Q_W-1:0]   w_q;
    logic                    r_v1, r_in1;
    logic signed [XR_W-1:0]  r_xr1;
    logic signed [MUL_W-1:0] r_mul;
    logic signed [CMP_W-1:0] w_lhs, w_rhs;
    logic                    r_valid;
    logic [7:0]              r_alpha;
    t_region                 r_region;

    assign w_last = w_chain[ROOT_W];
    assign w_q    = $signed({1'b0, r_frac}) - $signed(Q_W'(32768));
    assign w_lhs  = CMP_W'(r_xr1) <<< 15;
    assign w_rhs  = CMP_W'(r_mul);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= w_last.valid;
            r_valid <= r_v1;
        end
        r_in1 <= w_last.in_disc;
        r_xr1 <= w_last.xr;
        r_mul <= MUL_W'(w_q * $signed({1'b0, w_last.root}));
        if (!r_in1) begin
            r_alpha  <= ALPHA_OUTSIDE;
            r_region <= REGION_OUT;
        end else if (w_lhs <= w_rhs) begin
            r_alpha  <= ALPHA_LIT;
            r_region <= REGION_LIT;
        end else begin
            r_alpha  <= ALPHA_SHADED;
            r_region <= REGION_SHADE;
        end
    end

    assign o_valid  = r_valid;
    assign o_alpha  = r_alpha;
    assign o_region = r_region;

`ifndef NO_ASSERTIONS
    a_out_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_region == REGION_OUT |-> o_alpha == ALPHA_OUTSIDE)
        else $error("outside pixel with wrong alpha");
    a_lit_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_region == REGION_LIT |-> o_alpha == ALPHA_LIT)
        else $error("lit pixel with wrong alpha");
    a_shade_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_region == REGION_SHADE |-> o_alpha == ALPHA_SHADED)
        else $error("shaded pixel with wrong alpha");
    a_chain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |=> r_v1)
        else $error("word lost leaving the root chain");
`endif

endmodule
